FILE: rtl/rpi_pkg.sv
// ----------------------------------------------------------------------------
// rpi_pkg: shared types of the RGB palette indexer
// Probe record that walks the cell chain and the result record that the
// output buffer holds.
// ----------------------------------------------------------------------------
`default_nettype none

package rpi_pkg;

   localparam int COLOR_W = 32;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 9;

   // A probe carries one pixel through the palette cells.
   typedef struct packed {
      logic               valid;
      logic               done;
      logic               added;
      logic [COLOR_W-1:0] color;
      logic [INDEX_W-1:0] index;
   } probe_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               added;
      logic               overflow;
      logic [COUNT_W-1:0] count;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/rpi_cell.sv
// ----------------------------------------------------------------------------
// rpi_cell: one palette entry of the indexer chain
// Holds one stored color, compares the passing probe against it, takes the
// color when the probe reaches the first free entry, and hands the probe on.
// ----------------------------------------------------------------------------
`default_nettype none

module rpi_cell #(
   parameter int CELL_INDEX = 0,
   parameter int LIMIT_W    = 9
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [LIMIT_W-1:0]   limit,
   input  wire rpi_pkg::probe_type   probe_in,
   output rpi_pkg::probe_type        probe_out
);
   import rpi_pkg::*;

   localparam logic [LIMIT_W-1:0] CELL_K = LIMIT_W'(CELL_INDEX);
   localparam logic [INDEX_W-1:0] CELL_I = INDEX_W'(CELL_INDEX);

   logic [COLOR_W-1:0] entry_ff;
   probe_type          probe_ff;
   probe_type          probe_in_next;
   logic               searching;
   logic               hit;
   logic               insert;

   assign searching = probe_in.valid && !probe_in.done;
   // Only entries below the current count hold colors of this image.
   assign hit    = searching && (CELL_K < limit) && (entry_ff == probe_in.color);
   assign insert = searching && (CELL_K == limit);

   always_comb begin
      probe_in_next = probe_in;
      if (hit || insert) begin
         probe_in_next.done  = 1'b1;
         probe_in_next.index = CELL_I;
      end
      if (insert) begin
         probe_in_next.added = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         entry_ff <= probe_in.color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in_next.valid;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff.done  <= probe_in_next.done;
      probe_ff.added <= probe_in_next.added;
      probe_ff.color <= probe_in_next.color;
      probe_ff.index <= probe_in_next.index;
   end

   assign probe_out = probe_ff;

endmodule

`default_nettype wire

FILE: rtl/rpi_rsp_buffer.sv
// ----------------------------------------------------------------------------
// rpi_rsp_buffer: two-place result buffer
// An output register with a skid place behind it, so a finished result can
// wait while the next pixel is already taken in.
// ----------------------------------------------------------------------------
`default_nettype none

module rpi_rsp_buffer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 done_valid,
   input  wire rpi_pkg::result_type  done_result,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output rpi_pkg::result_type       rsp_result,
   output logic                      room
);
   import rpi_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type rsp_ff, rsp_in;
   result_type skid_ff, skid_in;
   logic       take;

   assign take = rsp_valid_ff && rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!rsp_valid_ff || take) begin
         rsp_valid_in  = skid_valid_ff || done_valid;
         rsp_in        = skid_valid_ff ? skid_ff : done_result;
         skid_valid_in = skid_valid_ff && done_valid;
         skid_in       = done_result;
      end else if (done_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = done_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;
   assign room       = !skid_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/rgb_palette_indexer.sv
// ----------------------------------------------------------------------------
// rgb_palette_indexer: exact-color palette builder for RGBA pixel streams
// Assigns each 32-bit RGBA color a palette index in first-seen order.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the req_ channel (valid/ready), one transaction per
//   pixel; req_first_pixel starts a new image and clears the color count and
//   the sticky overflow flag. Each pixel yields one rsp_ transaction with its
//   palette index, a new-entry mark, the overflow flag and the color count.
//   A pixel walks a row of PALETTE_ENTRIES cells, one cell per cycle, each
//   cell holding one palette color. The result passes the launch register,
//   the cells and the output register. One pixel is in the row at a time:
//   a new pixel is taken only once the previous one has left the row.
//   Reset empties the palette and clears the overflow flag; palette entries
//   themselves are not cleared, since only entries below the count are read.
//   When the receiver stalls, one finished result waits in the output
//   register and one more pixel may still be accepted and finished into a
//   skid register; after that req_ready stays low until rsp_ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_palette_indexer #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   input  wire logic [7:0] req_alpha,
   input  wire logic       req_first_pixel,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_palette_index,
   output logic            rsp_new_entry,
   output logic            rsp_overflow,
   output logic [8:0]      rsp_color_count
);
   import rpi_pkg::*;

   localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PALETTE_ENTRIES);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic             busy_ff, busy_in;
   probe_type        launch_ff, launch_in;
   probe_type        chain [0:PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES:0] chain_valid;
   probe_type        tail;
   logic             accept;
   logic             room;
   logic             done_valid;
   result_type       done_result;
   result_type       rsp_result;

   assign req_ready = !busy_ff && room;
   assign accept    = req_valid && req_ready;
   assign tail      = chain[PALETTE_ENTRIES];

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      busy_in     = busy_ff;
      launch_in   = launch_ff;
      launch_in.valid = 1'b0;
      if (accept) begin
         busy_in = 1'b1;
         if (req_first_pixel) begin
            count_in    = '0;
            overflow_in = 1'b0;
         end
         // With overflow already set the probe travels as finished, index 0.
         launch_in.valid = 1'b1;
         launch_in.done  = req_first_pixel ? 1'b0 : overflow_ff;
         launch_in.added = 1'b0;
         launch_in.color = {req_alpha, req_blue, req_green, req_red};
         launch_in.index = '0;
      end else if (tail.valid) begin
         busy_in = 1'b0;
         if (!tail.done) begin
            overflow_in = 1'b1;
         end else if (tail.added) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         overflow_ff     <= 1'b0;
         busy_ff         <= 1'b0;
         launch_ff.valid <= 1'b0;
      end else begin
         count_ff        <= count_in;
         overflow_ff     <= overflow_in;
         busy_ff         <= busy_in;
         launch_ff.valid <= launch_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      launch_ff.done  <= launch_in.done;
      launch_ff.added <= launch_in.added;
      launch_ff.color <= launch_in.color;
      launch_ff.index <= launch_in.index;
   end

   assign chain[0]       = launch_ff;
   assign chain_valid[0] = launch_ff.valid;

   for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
      rpi_cell #(
         .CELL_INDEX (k),
         .LIMIT_W    (CNT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .limit     (count_ff),
         .probe_in  (chain[k]),
         .probe_out (chain[k+1])
      );
      assign chain_valid[k+1] = chain[k+1].valid;
   end

   assign done_valid           = tail.valid;
   assign done_result.index    = tail.index;
   assign done_result.added    = tail.added;
   assign done_result.overflow = overflow_ff || !tail.done;
   assign done_result.count    = COUNT_W'(count_ff) + COUNT_W'(tail.added);

   rpi_rsp_buffer u_rsp_buffer (
      .clock       (clock),
      .reset       (reset),
      .done_valid  (done_valid),
      .done_result (done_result),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_result  (rsp_result),
      .room        (room)
   );

   assign rsp_palette_index = rsp_result.index;
   assign rsp_new_entry     = rsp_result.added;
   assign rsp_overflow      = rsp_result.overflow;
   assign rsp_color_count   = rsp_result.count;

   // At most one pixel is ever in the cell row.
   a_single_probe : assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one probe in the cell row");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("color count above palette size");

   // A new entry can only be added while the palette has room.
   a_add_has_room : assert property (@(posedge clock) disable iff (reset)
      tail.valid && tail.added |-> count_ff < FULL_COUNT && !overflow_ff)
      else $error("entry added to a full or overflowed palette");

   // The skid place fills only behind a waiting result.
   a_skid_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      !room |-> rsp_valid)
      else $error("skid result held without a pending response");

   a_busy_tracks_probe : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && launch_ff.valid)
      else $error("accepted pixel not launched into the cell row");

endmodule

`default_nettype wire
